// ===== hw/rtl/sest_pkg.sv =====
// Shared constants for the scanline edge span table.
// Holds coordinate widths, the empty-extent value and the operation codes.
// No dependencies.
`default_nettype none

package sest_pkg;

  localparam int COORD_W         = 9;
  localparam int OP_W            = 2;
  localparam int SCREEN_SIZE_DEF = 512;

  localparam logic [COORD_W-1:0] EXT_MAX = {COORD_W{1'b1}};

  localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
  localparam logic [OP_W-1:0] OP_EDGE  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/scanline_edge_span_table.sv =====
// Top level of the scanline edge span table: per-row left/right extent memories,
// divider-plus-walk sequencer for edges and the query output register.
// Depends on sest_pkg.
`default_nettype none

// Scan-line fill extent table. Each of SCREEN_SIZE rows holds a left and a right
// x extent in two on-chip memories (one write and one registered read per cycle
// each). After reset the block runs a clearing pass with in_ready low. A clear
// word runs the same pass after its accept (one row written per cycle). An edge
// word orders its endpoints by y, runs a restoring divider for the integer and
// fractional x step (one quotient bit per cycle), then walks one row per cycle
// over dy = |end_y - start_y| rows, the read-modify-write of each row overlapping
// the read of the next; a horizontal edge or an unused operation leaves the block
// idle. A query reads its row in S_QRD and registers the result in S_QOUT,
// waiting there while the previous result is still held in the output register.
// One word is processed at a time; clear and edge words are accepted while a
// query result waits to be taken. Rows at or above SCREEN_SIZE are skipped, and a
// query for one returns the empty span (start all ones, end zero).
module scanline_edge_span_table #(
  parameter int SCREEN_SIZE = sest_pkg::SCREEN_SIZE_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [sest_pkg::OP_W-1:0]    operation,
  input  wire logic [sest_pkg::COORD_W-1:0] start_x,
  input  wire logic [sest_pkg::COORD_W-1:0] start_y,
  input  wire logic [sest_pkg::COORD_W-1:0] end_x,
  input  wire logic [sest_pkg::COORD_W-1:0] end_y,
  input  wire logic [sest_pkg::COORD_W-1:0] row,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [sest_pkg::COORD_W-1:0]      span_start,
  output logic [sest_pkg::COORD_W-1:0]      span_end,
  output logic                              span_valid
);
  import sest_pkg::*;

  localparam int AW    = $clog2(SCREEN_SIZE);
  localparam int DIV_CW = $clog2(COORD_W + 1);
  localparam logic [AW-1:0]     LAST_ROW = AW'(SCREEN_SIZE - 1);
  localparam logic [DIV_CW-1:0] DIV_LAST = DIV_CW'(COORD_W - 1);

  // sequencer state codes
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WALK = 3'd3;
  localparam logic [2:0] S_QRD  = 3'd4;
  localparam logic [2:0] S_QOUT = 3'd5;

  logic [2:0] state;

  // extent memories
  logic [COORD_W-1:0] left_mem  [SCREEN_SIZE];
  logic [COORD_W-1:0] right_mem [SCREEN_SIZE];
  logic [COORD_W-1:0] rd_left;
  logic [COORD_W-1:0] rd_right;

  // clearing sweep
  logic [AW-1:0] clr_cnt;

  // edge operands, held for the walk
  logic [COORD_W-1:0] x0;
  logic [COORD_W-1:0] y1;
  logic [COORD_W-1:0] dy;
  logic               neg;

  // divider: dvd starts as |dx| and ends as the quotient
  logic [COORD_W-1:0] dvd;
  logic [COORD_W-1:0] drem;
  logic [DIV_CW-1:0]  div_cnt;
  logic [COORD_W:0]   div_trial;
  logic               div_fit;

  // walk accumulators: integer offset and fractional remainder
  logic [COORD_W-1:0] cur_row;
  logic [COORD_W-1:0] off;
  logic [COORD_W-1:0] frac;
  logic [COORD_W:0]   frac_sum;
  logic               frac_carry;
  logic [COORD_W-1:0] walk_x;

  // pipelined update stage, one row behind the read
  logic               p_valid;
  logic [AW-1:0]      p_addr;
  logic [COORD_W-1:0] p_x;

  // query
  logic q_ok;

  logic [AW+COORD_W-1:0] row_wide;
  logic [AW-1:0]         rd_addr;
  logic                  row_in_table;

  logic               wl_en;
  logic               wr_en;
  logic [AW-1:0]      w_addr;
  logic [COORD_W-1:0] wl_data;
  logic [COORD_W-1:0] wr_data;

  logic accept;
  logic swap;
  logic out_free;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign swap     = end_y < start_y;
  assign out_free = !out_valid || out_ready;

  // Map the 9-bit row onto the table address; out-of-table rows never write.
  assign row_wide     = {{AW{1'b0}}, cur_row};
  assign rd_addr      = row_wide[AW-1:0];
  assign row_in_table = 32'(cur_row) < SCREEN_SIZE;

  // Restoring divider step: shift in the next dividend bit, subtract if it fits.
  assign div_trial = {drem, dvd[COORD_W-1]};
  assign div_fit   = div_trial >= {1'b0, dy};

  // x on the current row, then the exact step to the next row.
  assign walk_x     = neg ? (x0 - off) : (x0 + off);
  assign frac_sum   = {1'b0, frac} + {1'b0, drem};
  assign frac_carry = frac_sum >= {1'b0, dy};

  // Write port: the sweep owns it while clearing, else the widen stage.
  always_comb begin
    if (state == S_CLR) begin
      wl_en   = 1'b1;
      wr_en   = 1'b1;
      w_addr  = clr_cnt;
      wl_data = EXT_MAX;
      wr_data = '0;
    end else begin
      wl_en   = p_valid && (p_x < rd_left);
      wr_en   = p_valid && (p_x > rd_right);
      w_addr  = p_addr;
      wl_data = p_x;
      wr_data = p_x;
    end
  end

  always_ff @(posedge clk) begin
    if (wl_en) begin
      left_mem[w_addr] <= wl_data;
    end
    if (wr_en) begin
      right_mem[w_addr] <= wr_data;
    end
    rd_left  <= left_mem[rd_addr];
    rd_right <= right_mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      p_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      p_valid <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_CLR: begin
          if (clr_cnt == LAST_ROW) begin
            state <= S_IDLE;
          end else begin
            clr_cnt <= clr_cnt + 1'b1;
          end
        end

        S_IDLE: begin
          if (accept) begin
            case (operation)
              OP_CLEAR: begin
                clr_cnt <= '0;
                state   <= S_CLR;
              end
              OP_EDGE: begin
                // order endpoints by y; a horizontal edge touches nothing
                if (start_y != end_y) begin
                  state <= S_DIV;
                end
              end
              OP_QUERY: begin
                state <= S_QRD;
              end
              default: begin
              end
            endcase
          end
        end

        S_DIV: begin
          if (div_cnt == DIV_LAST) begin
            state <= S_WALK;
          end
        end

        S_WALK: begin
          p_valid <= row_in_table;
          if (cur_row + 1'b1 == y1) begin
            state <= S_IDLE;
          end
        end

        S_QRD: begin
          state <= S_QOUT;
        end

        S_QOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (operation == OP_QUERY) begin
            cur_row <= row;
            q_ok    <= 32'(row) < SCREEN_SIZE;
          end else begin
            x0      <= swap ? end_x : start_x;
            cur_row <= swap ? end_y : start_y;
            y1      <= swap ? start_y : end_y;
            dy      <= swap ? (start_y - end_y) : (end_y - start_y);
            neg     <= swap ? (start_x < end_x) : (end_x < start_x);
            dvd     <= swap ? ((start_x < end_x) ? end_x - start_x : start_x - end_x)
                            : ((end_x < start_x) ? start_x - end_x : end_x - start_x);
            drem    <= '0;
            div_cnt <= '0;
          end
        end
      end

      S_DIV: begin
        dvd     <= {dvd[COORD_W-2:0], div_fit};
        drem    <= div_fit ? COORD_W'(div_trial - {1'b0, dy}) : div_trial[COORD_W-1:0];
        div_cnt <= div_cnt + 1'b1;
        off     <= '0;
        frac    <= '0;
      end

      S_WALK: begin
        // hand this row to the widen stage, advance to the next one
        p_addr  <= rd_addr;
        p_x     <= walk_x;
        cur_row <= cur_row + 1'b1;
        off     <= off + dvd + {{(COORD_W-1){1'b0}}, frac_carry};
        frac    <= frac_carry ? COORD_W'(frac_sum - {1'b0, dy}) : frac_sum[COORD_W-1:0];
      end

      S_QOUT: begin
        if (out_free) begin
          span_start <= q_ok ? rd_left : EXT_MAX;
          span_end   <= q_ok ? rd_right : '0;
          span_valid <= q_ok && (rd_left < rd_right);
        end
      end

      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sest_checker.sv =====
// Port-level checks for the scanline edge span table, bound to its top level.
// Depends on sest_pkg.
`default_nettype none

module sest_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic [sest_pkg::OP_W-1:0]    operation,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [sest_pkg::COORD_W-1:0] span_start,
  input wire logic [sest_pkg::COORD_W-1:0] span_end,
  input wire logic                         span_valid
);
  import sest_pkg::*;

  // Reset starts the clearing pass: nothing accepted, no result shown.
  a_reset_busy: assert property (@(posedge clk)
    rst |=> (!in_ready && !out_valid))
    else $error("block ready or result shown right after reset");

  // A held result keeps its fields.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(span_start) &&
                                   $stable(span_end) && $stable(span_valid)))
    else $error("result dropped or changed while stalled");

  // The valid flag always matches the span it comes with.
  a_span_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (span_valid == (span_start < span_end)))
    else $error("span_valid disagrees with span bounds");

  // A clear or a query keeps the block busy in the next cycle.
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (operation == OP_CLEAR || operation == OP_QUERY))
      |=> !in_ready)
    else $error("ready high right after accepting clear or query");

endmodule

bind scanline_edge_span_table sest_checker u_sest_checker (.*);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for scanline_edge_span_table: clear, edge and span query words.
// Keeps its own copy of the per-row extent table, predicts every span and checks each result.
// Depends on sest_pkg and the scanline_edge_span_table RTL.
`default_nettype none

module tb;
  import sest_pkg::*;

  // Operation 3 has no meaning; the block must drop it without a result.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The worst word is a full-height edge or a clear; the whole run, with heavy
  // idling on both sides, stays well below this.
  localparam int CYCLE_LIMIT  = 2_000_000;
  // Quiet time after the last result: covers a trailing clear or tall edge.
  localparam int DRAIN_CYCLES = 600;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t s_start;
    coord_t s_stop;
    logic   s_nonempty;
  } span_t;

  logic              clk;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   operation  = OP_CLEAR;
  coord_t            start_x    = '0;
  coord_t            start_y    = '0;
  coord_t            end_x      = '0;
  coord_t            end_y      = '0;
  coord_t            row        = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  coord_t            span_start;
  coord_t            span_end;
  logic              span_valid;

  // Shadow copy of the row extent table.
  coord_t table_left  [SCREEN_SIZE_DEF];
  coord_t table_right [SCREEN_SIZE_DEF];

  // Spans owed by the block, oldest first.
  span_t  pending_spans[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_req     = 0;
  int stall_left    = 0;
  int cycle_count   = 0;
  int n_errors      = 0;
  int n_words       = 0;
  int n_edges       = 0;
  int n_spans       = 0;

  scanline_edge_span_table u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .start_x    (start_x),
    .start_y    (start_y),
    .end_x      (end_x),
    .end_y      (end_y),
    .row        (row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .span_start (span_start),
    .span_end   (span_end),
    .span_valid (span_valid)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Extent table predictor
  // ---------------------------------------------------------------------------

  // Reset every row to the empty extent: left at maximum, right at zero.
  function automatic void wipe_extents();
    for (int i = 0; i < SCREEN_SIZE_DEF; i++) begin
      table_left[i]  = EXT_MAX;
      table_right[i] = '0;
    end
  endfunction

  // Walk the rows from the lower y up to, not including, the upper y and widen
  // each row with x = x0 +/- trunc((r - y0) * |dx| / dy).
  function automatic void widen_along_edge(input coord_t xa, input coord_t ya,
                                           input coord_t xb, input coord_t yb);
    coord_t      x0, y0, x1, y1, xr;
    int unsigned dy, mag, off;
    bit          neg;
    int          r;
    if (yb < ya) begin
      x0 = xb; y0 = yb; x1 = xa; y1 = ya;
    end else begin
      x0 = xa; y0 = ya; x1 = xb; y1 = yb;
    end
    dy = 32'(y1) - 32'(y0);
    // A horizontal edge covers no row.
    if (dy == 0) return;
    neg = x1 < x0;
    mag = neg ? 32'(x0) - 32'(x1) : 32'(x1) - 32'(x0);
    for (r = int'(y0); r < int'(y1); r++) begin
      off = (32'(r - int'(y0)) * mag) / dy;
      xr  = coord_t'(neg ? 32'(x0) - off : 32'(x0) + off);
      if (r < SCREEN_SIZE_DEF) begin
        if (xr < table_left[r])  table_left[r]  = xr;
        if (xr > table_right[r]) table_right[r] = xr;
      end
    end
  endfunction

  // A row outside the table reads as the empty span.
  function automatic span_t lookup_span(input coord_t r);
    span_t s;
    s.s_start = EXT_MAX;
    s.s_stop  = '0;
    if (int'(r) < SCREEN_SIZE_DEF) begin
      s.s_start = table_left[r];
      s.s_stop  = table_right[r];
    end
    s.s_nonempty = s.s_start < s.s_stop;
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Word sender: one handshake per call, prediction at the accepting edge
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [OP_W-1:0] op, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey, input coord_t rw);
    // Drop valid for a random number of cycles before offering the word.
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    start_x   <= sx;
    start_y   <= sy;
    end_x     <= ex;
    end_y     <= ey;
    row       <= rw;
    // Hold the word until the block takes it.
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (op)
      OP_CLEAR: wipe_extents();
      OP_EDGE: begin
        widen_along_edge(sx, sy, ex, ey);
        n_edges++;
      end
      OP_QUERY: pending_spans.push_back(lookup_span(rw));
      default: ;
    endcase
    if (op != OP_UNUSED) n_words++;
  endtask

  task automatic send_edge(input coord_t sx, input coord_t sy, input coord_t ex,
                           input coord_t ey);
    send_word(OP_EDGE, sx, sy, ex, ey, coord_t'($urandom_range(511)));
  endtask

  task automatic send_query(input coord_t rw);
    send_word(OP_QUERY, coord_t'($urandom_range(511)), coord_t'($urandom_range(511)),
              coord_t'($urandom_range(511)), coord_t'($urandom_range(511)), rw);
  endtask

  task automatic send_clear();
    send_word(OP_CLEAR, coord_t'($urandom_range(511)), coord_t'($urandom_range(511)),
              coord_t'($urandom_range(511)), coord_t'($urandom_range(511)),
              coord_t'($urandom_range(511)));
  endtask

  // ---------------------------------------------------------------------------
  // Result side: receiver stalls and span checker
  // ---------------------------------------------------------------------------

  // Random back-pressure, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (stall_req != 0) begin
      stall_left = stall_req;
      stall_req  = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    n_errors++;
  endtask

  // Compare every taken result against the oldest owed span.
  always @(posedge clk) begin : check_span
    span_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_spans.size() == 0) begin
        report_mismatch("result with nothing owed, span_start", span_start, 0);
      end else begin
        want = pending_spans.pop_front();
        n_spans++;
        if (span_start !== want.s_start)
          report_mismatch("span_start", span_start, want.s_start);
        if (span_end !== want.s_stop)
          report_mismatch("span_end", span_end, want.s_stop);
        if (span_valid !== want.s_nonempty)
          report_mismatch("span_valid", span_valid, want.s_nonempty);
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d spans still owed", cycle_count,
               pending_spans.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Fresh table after the clearing pass: every row reads empty.
  task automatic test_empty_rows();
    send_query(9'd0);
    send_query(9'd511);
    send_query(9'd256);
  endtask

  // Full-range diagonals both ways, a near-vertical and a near-flat edge.
  task automatic test_edge_extremes();
    send_edge(9'd0, 9'd0, 9'd511, 9'd511);
    send_query(9'd0);
    send_query(9'd510);
    send_edge(9'd0, 9'd511, 9'd511, 9'd0);     // endpoints given top first
    send_query(9'd255);
    send_edge(9'd100, 9'd0, 9'd101, 9'd511);
    send_edge(9'd511, 9'd201, 9'd0, 9'd200);
    send_query(9'd200);
    send_query(9'd511);                         // top row is exclusive, stays empty
  endtask

  // A horizontal edge must leave its row alone.
  task automatic test_horizontal_edge();
    send_edge(9'd3, 9'd300, 9'd508, 9'd300);
    send_query(9'd300);
  endtask

  // Operation 3 with every field at its extremes gives nothing.
  task automatic test_unused_operation();
    send_word(OP_UNUSED, 9'd511, 9'd511, 9'd511, 9'd511, 9'd511);
    send_word(OP_UNUSED, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
    send_query(9'd300);
  endtask

  task automatic test_clear_table();
    send_clear();
    send_query(9'd255);
    send_query(9'd0);
  endtask

  // Hold the result side off for a long stretch while spans and edges keep
  // coming, so the output register and the input both back up.
  task automatic test_output_backpressure();
    stall_req = 400;
    repeat (4) send_query(coord_t'($urandom_range(511)));
    send_edge(coord_t'($urandom_range(511)), 9'd20, coord_t'($urandom_range(511)), 9'd60);
    repeat (4) send_query(coord_t'($urandom_range(20, 60)));
  endtask

  // Mostly closed polygons with random vertices inside a random band of rows,
  // followed by span lookups in that band; the rest is random noise words.
  task automatic test_random_polygons(input int n_items, input int send_pct,
                                      input int recv_pct);
    int     target, n_vert, n_look, height, y_low;
    coord_t vx [6];
    coord_t vy [6];
    logic [OP_W-1:0] op;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = n_words + n_items;
    while (n_words < target) begin
      if ($urandom_range(99) < 15) begin
        op = OP_W'($urandom_range(3));
        send_word(op, coord_t'($urandom_range(511)), coord_t'($urandom_range(511)),
                  coord_t'($urandom_range(511)), coord_t'($urandom_range(511)),
                  coord_t'($urandom_range(511)));
      end else begin
        if ($urandom_range(1) == 0) send_clear();
        n_vert = $urandom_range(3, 6);
        // Keep most bands short; a few span the whole screen.
        height = ($urandom_range(9) == 0) ? 511 : $urandom_range(1, 48);
        y_low  = $urandom_range(511 - height);
        for (int i = 0; i < n_vert; i++) begin
          vx[i] = coord_t'($urandom_range(511));
          vy[i] = coord_t'(y_low + $urandom_range(height));
        end
        for (int i = 0; i < n_vert; i++)
          send_edge(vx[i], vy[i], vx[(i + 1) % n_vert], vy[(i + 1) % n_vert]);
        n_look = $urandom_range(2, 8);
        for (int i = 0; i < n_look; i++) begin
          if ($urandom_range(9) == 0) send_query(coord_t'($urandom_range(511)));
          else send_query(coord_t'(y_low + $urandom_range(height)));
        end
      end
    end
  endtask

  initial begin
    wipe_extents();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_empty_rows();
    test_edge_extremes();
    test_horizontal_edge();
    test_unused_operation();
    test_clear_table();
    test_output_backpressure();

    // Light sender gaps with a sluggish receiver, then the reverse, then none.
    test_random_polygons(233, 8, 81);
    test_random_polygons(233, 81, 8);
    test_random_polygons(234, 0, 0);

    // Release the input, wait out owed spans, then let any trailing walk finish.
    in_valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d words (%0d edges) and checked %0d row spans", n_words,
             n_edges, n_spans);
    $display("idle mixes: sender-light, receiver-light, none; one long output hold-off");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
